// ----- design/step_function_interval_integral_assert.svh -----
// Assertion macros for the step function integrator RTL
`ifndef STEP_FUNCTION_INTERVAL_INTEGRAL_ASSERT_SVH
`define STEP_FUNCTION_INTERVAL_INTEGRAL_ASSERT_SVH
`ifndef SYNTH
`define SFII_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SFII_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFII_ASSERT_IMP(lbl, ante, cons, msg)
`define SFII_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/sfii_pkg.sv -----
// Types, codes and helpers for the step function integrator
package sfii_pkg;

	localparam int DEF_POINTS = 256;
	localparam int DATA_W     = 32;
	localparam int COUNT_W    = 9;
	localparam int RESULT_W   = 64;
	localparam int REG_IDX_W  = 1;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_BASE_LEVEL  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 1'b1;

	// one breakpoint as held in the memory
	typedef struct packed {
		logic signed [DATA_W-1:0] t;
		logic signed [DATA_W-1:0] lev;
	} bp_t;

	// one product term handed to the multiply-accumulate unit
	typedef struct packed {
		logic                     clear;
		logic                     valid;
		logic signed [DATA_W:0]   diff;
		logic signed [DATA_W-1:0] lev;
	} mac_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK0,
		S_CHKT,
		S_EDEC,
		S_LOC_RD,
		S_LOC_CMP,
		S_BR,
		S_GETFL,
		S_GETSL,
		S_WALK,
		S_FINAL,
		S_DRAIN,
		S_DONE
	} st_t;

	function automatic logic signed [DATA_W:0] sub33(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		return {a[DATA_W-1], a} - {b[DATA_W-1], b};
	endfunction

	function automatic mac_ctl_t mk_term(
		input logic signed [DATA_W:0]   diff,
		input logic signed [DATA_W-1:0] lev
	);
		mac_ctl_t m;
		m.clear = 1'b0;
		m.valid = 1'b1;
		m.diff  = diff;
		m.lev   = lev;
		return m;
	endfunction

endpackage

// ----- design/sfii_mem.sv -----
// Breakpoint store: one write port, one read port with registered data
module sfii_mem #(
	parameter int POINTS = sfii_pkg::DEF_POINTS
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(POINTS)-1:0]   waddr,
	input  sfii_pkg::bp_t               wdata,
	input  logic [$clog2(POINTS)-1:0]   raddr,
	output sfii_pkg::bp_t               rdata
);
	import sfii_pkg::*;

	bp_t mem_q [POINTS];
	bp_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/sfii_mac.sv -----
// Two-stage multiply-accumulate for the segment terms, wrapping at 64 bits
module sfii_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sfii_pkg::mac_ctl_t                ctl,
	output logic                              busy,
	output logic [sfii_pkg::RESULT_W-1:0]     acc
);
	import sfii_pkg::*;

	logic                     v_s1;
	logic signed [DATA_W:0]   diff_s1;
	logic signed [DATA_W-1:0] lev_s1;
	logic                     v_s2;
	logic [RESULT_W-1:0]      prod_s2;
	logic [RESULT_W-1:0]      acc_q;
	logic signed [RESULT_W:0] prod;

	assign prod = diff_s1 * lev_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= ctl.diff;
		lev_s1  <= ctl.lev;
		prod_s2 <= prod[RESULT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign busy = v_s1 | v_s2;
	assign acc  = acc_q;

endmodule

// ----- design/step_function_interval_integral.sv -----
// Top level: step function store and interval integrator
// A step function is held as a base level plus up to POINTS breakpoints (time, level) in one
// synchronous memory. A write word (func = 0) stores one breakpoint and gives no result;
// writes to a slot at or above POINTS are dropped. A query word (func = 1) returns
// the exact integral over (query_start, query_end], zero for an empty interval, wrapping at
// 64 bits. Queries locate both ends by binary search and then walk the whole segments in
// between, one memory read a cycle; the single read port of the breakpoint memory sets this
// pace. The block works on one word at a time; a finished result sits in the output register,
// so the next word is taken while it waits. point_count above POINTS counts as POINTS.
// Reading a breakpoint that was never written gives an unspecified result.
`include "step_function_interval_integral_assert.svh"
module step_function_interval_integral #(
	parameter int POINTS = sfii_pkg::DEF_POINTS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sfii_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [sfii_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  func,
	input  logic [7:0]                            slot,
	input  logic signed [sfii_pkg::DATA_W-1:0]    point_time,
	input  logic signed [sfii_pkg::DATA_W-1:0]    point_level,
	input  logic signed [sfii_pkg::DATA_W-1:0]    query_start,
	input  logic signed [sfii_pkg::DATA_W-1:0]    query_end,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [sfii_pkg::RESULT_W-1:0]  integral
);
	import sfii_pkg::*;

	localparam int IW = $clog2(POINTS);
	localparam int CW = ($clog2(POINTS + 1) > COUNT_W) ? $clog2(POINTS + 1) : COUNT_W;

	// configuration
	logic signed [DATA_W-1:0] base_level_q;
	logic [COUNT_W-1:0]       point_count_q;

	// sequencer state
	st_t state_q, state_d;
	logic signed [DATA_W-1:0] s_q, s_d, e_q, e_d;
	logic signed [DATA_W-1:0] tb_q, tb_d, tt_q, tt_d, vt_q, vt_d;
	logic signed [DATA_W-1:0] prev_t_q, prev_t_d, prev_l_q, prev_l_d;
	logic [CW-1:0]            n_q, n_d;
	logic [IW-1:0]            lo_q, lo_d, hi_q, hi_d;
	logic [IW-1:0]            sl_q, sl_d, su_q, su_d, fl_q, fl_d;
	logic                     loc_e_q, loc_e_d;
	logic [IW:0]              wj_q, wj_d;
	logic                     pend_q, pend_d;
	logic                     out_valid_q, out_valid_d;
	logic signed [RESULT_W-1:0] integral_q;
	logic                     out_load;

	// datapath
	logic                     mem_we;
	logic [IW-1:0]            rd_addr;
	bp_t                      wr_bp, rd_bp;
	mac_ctl_t                 mac_ctl;
	logic                     mac_busy;
	logic [RESULT_W-1:0]      mac_acc;
	logic                     slot_ok;
	logic [CW-1:0]            n_eff;
	logic [IW-1:0]            top;
	logic [IW:0]              mid_sum;
	logic [IW-1:0]            mid;
	logic [IW:0]              fl_ext;
	logic signed [DATA_W-1:0] rt, rl, loc_t;

	assign slot_ok = CW'(slot) < CW'(POINTS);
	assign n_eff   = (CW'(point_count_q) > CW'(POINTS)) ? CW'(POINTS) : CW'(point_count_q);
	assign top     = IW'(n_q - CW'(1));
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IW:1];
	assign fl_ext  = {1'b0, fl_q};
	assign rt      = rd_bp.t;
	assign rl      = rd_bp.lev;
	assign loc_t   = loc_e_q ? e_q : s_q;

	assign wr_bp.t   = point_time;
	assign wr_bp.lev = point_level;

	sfii_mem #(
		.POINTS(POINTS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(IW'(slot)),
		.wdata(wr_bp),
		.raddr(rd_addr),
		.rdata(rd_bp)
	);

	sfii_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.busy  (mac_busy),
		.acc   (mac_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_level_q  <= '0;
			point_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_LEVEL:  base_level_q  <= cfg_data;
				REG_POINT_COUNT: point_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_d      = s_q;
		e_d      = e_q;
		tb_d     = tb_q;
		tt_d     = tt_q;
		vt_d     = vt_q;
		prev_t_d = prev_t_q;
		prev_l_d = prev_l_q;
		n_d      = n_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		sl_d     = sl_q;
		su_d     = su_q;
		fl_d     = fl_q;
		loc_e_d  = loc_e_q;
		wj_d     = wj_q;
		pend_d   = pend_q;
		out_load = 1'b0;
		mem_we   = 1'b0;
		rd_addr  = '0;
		mac_ctl  = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (func == FUNC_WRITE) begin
						mem_we = slot_ok;
					end else begin
						s_d = query_start;
						e_d = query_end;
						n_d = n_eff;
						if (!(query_start < query_end)) begin
							state_d = S_DRAIN;
						end else if (n_eff == '0) begin
							mac_ctl = mk_term(sub33(query_end, query_start), base_level_q);
							state_d = S_DRAIN;
						end else begin
							rd_addr = '0;
							state_d = S_CHK0;
						end
						mac_ctl.clear = 1'b1;
					end
				end
			end
			S_CHK0: begin
				if (!(rt < e_q)) begin
					mac_ctl = mk_term(sub33(e_q, s_q), base_level_q);
					state_d = S_DRAIN;
				end else if (n_q == CW'(1)) begin
					if (!(s_q < rt)) begin
						mac_ctl = mk_term(sub33(e_q, s_q), rl);
						state_d = S_DRAIN;
					end else begin
						mac_ctl  = mk_term(sub33(rt, s_q), base_level_q);
						prev_t_d = rt;
						prev_l_d = rl;
						state_d  = S_FINAL;
					end
				end else begin
					tb_d    = rt;
					rd_addr = top;
					state_d = S_CHKT;
				end
			end
			S_CHKT: begin
				if (!(s_q < rt)) begin
					mac_ctl = mk_term(sub33(e_q, s_q), rl);
					state_d = S_DRAIN;
				end else begin
					tt_d = rt;
					vt_d = rl;
					lo_d = '0;
					sl_d = '0;
					su_d = '0;
					if (tb_q < s_q) begin
						hi_d    = top;
						loc_e_d = 1'b0;
						state_d = S_LOC_RD;
					end else begin
						// start falls at or before the first breakpoint: base level up to it
						mac_ctl = mk_term(sub33(tb_q, s_q), base_level_q);
						s_d     = tb_q;
						state_d = S_EDEC;
					end
				end
			end
			S_EDEC: begin
				if (e_q < tt_q) begin
					lo_d    = sl_q;
					hi_d    = top;
					loc_e_d = 1'b1;
					state_d = S_LOC_RD;
				end else begin
					mac_ctl = mk_term(sub33(e_q, tt_q), vt_q);
					e_d     = tt_q;
					fl_d    = top;
					state_d = S_BR;
				end
			end
			S_LOC_RD: begin
				if ((hi_q - lo_q) > IW'(1)) begin
					rd_addr = mid;
					state_d = S_LOC_CMP;
				end else if (loc_e_q) begin
					fl_d    = lo_q;
					state_d = S_BR;
				end else begin
					sl_d    = lo_q;
					su_d    = hi_q;
					state_d = S_EDEC;
				end
			end
			S_LOC_CMP: begin
				if (!(rt < loc_t)) begin
					hi_d = mid;
				end else begin
					lo_d = mid;
				end
				state_d = S_LOC_RD;
			end
			S_BR: begin
				if (fl_q < su_q) begin
					rd_addr = fl_q;
					state_d = S_GETFL;
				end else begin
					rd_addr = sl_q;
					state_d = S_GETSL;
				end
			end
			S_GETFL: begin
				mac_ctl = mk_term(sub33(e_q, s_q), rl);
				state_d = S_DRAIN;
			end
			S_GETSL: begin
				prev_t_d = s_q;
				prev_l_d = rl;
				wj_d     = {1'b0, su_q};
				pend_d   = 1'b0;
				state_d  = S_WALK;
			end
			S_WALK: begin
				// streamed reads: the word read last cycle closes the segment before it
				if (pend_q) begin
					mac_ctl  = mk_term(sub33(rt, prev_t_q), prev_l_q);
					prev_t_d = rt;
					prev_l_d = rl;
				end
				if (wj_q <= fl_ext) begin
					rd_addr = wj_q[IW-1:0];
					pend_d  = 1'b1;
					wj_d    = wj_q + 1'b1;
				end else begin
					pend_d  = 1'b0;
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				mac_ctl = mk_term(sub33(e_q, prev_t_q), prev_l_q);
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!mac_busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			loc_e_q     <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			out_valid_q <= out_valid_d;
			loc_e_q     <= loc_e_d;
			pend_q      <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		s_q      <= s_d;
		e_q      <= e_d;
		tb_q     <= tb_d;
		tt_q     <= tt_d;
		vt_q     <= vt_d;
		prev_t_q <= prev_t_d;
		prev_l_q <= prev_l_d;
		n_q      <= n_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		sl_q     <= sl_d;
		su_q     <= su_d;
		fl_q     <= fl_d;
		wj_q     <= wj_d;
		if (out_load) begin
			integral_q <= mac_acc;
		end
	end

	assign out_valid = out_valid_q;
	assign integral  = integral_q;

	`SFII_ASSERT_IMP(a_loc_order, state_q == S_LOC_RD || state_q == S_LOC_CMP, lo_q < hi_q, "bounds crossed")
	`SFII_ASSERT_IMP(a_walk_range, state_q == S_WALK, su_q <= fl_q, "walk range empty")
	`SFII_ASSERT_IMP(a_done_drained, state_q == S_DONE, !mac_busy, "accumulator not drained")
	`SFII_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "stray result")

endmodule
